/* src/tcat_pkg.sv */
// ----------------------------------------------------------------------------
// tcat_pkg
// Shared types, codes and polynomial coefficients of the type K converter.
// ----------------------------------------------------------------------------
package tcat_pkg;

    localparam int ADC_W   = 12;
    localparam int AMB_W   = 9;    // ambient degrees, at most 409
    localparam int COEF_FR = 48;
    localparam int NCOEF   = 10;
    localparam int NSTEP   = NCOEF - 1;
    localparam int MEAS_W  = 15;   // whole degrees of an accumulator up to 2^62

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OPEN  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_BELOW = 2'd3;

    localparam logic [1:0] LNK_NONE = 2'd0;
    localparam logic [1:0] LNK_FAIL = 2'd1;
    localparam logic [1:0] LNK_PASS = 2'd2;

    localparam logic [1:0] REG_OPEN  = 2'd0;
    localparam logic [1:0] REG_RANGE = 2'd1;
    localparam logic [1:0] REG_GAIN  = 2'd2;
    localparam logic [1:0] REG_ERR   = 2'd3;

    localparam logic signed [63:0] ACC_LIM = 64'sd1 <<< 62;

    typedef struct packed {
        logic [1:0]       status;
        logic [1:0]       link;
        logic [AMB_W-1:0] amb;
    } t_side;

    // mant / 10^exp10 scaled by 2^48, truncated toward zero
    function automatic logic signed [63:0] make_coef(input longint mant, input int exp10);
        logic [127:0] den;
        logic [127:0] num;
        logic [127:0] rem;
        logic [127:0] quo;
        int           i;
        den = 128'd1;
        for (i = 0; i < exp10; i++) begin
            den = den * 128'd10;
        end
        num = 128'(mant < 0 ? -mant : mant) << COEF_FR;
        rem = '0;
        quo = '0;
        for (i = 127; i >= 0; i--) begin
            rem = {rem[126:0], num[i]};
            quo = quo << 1;
            if (rem >= den) begin
                rem = rem - den;
                quo[0] = 1'b1;
            end
        end
        return (mant < 0) ? -$signed(quo[63:0]) : $signed(quo[63:0]);
    endfunction

    localparam logic signed [63:0] LO_COEF [NCOEF] = '{
        make_coef(0, 0), make_coef(2508355, 5), make_coef(7860106, 8),
        make_coef(-2503131, 7), make_coef(8315270, 8), make_coef(-1228034, 8),
        make_coef(9804036, 10), make_coef(-4413030, 11), make_coef(1057734, 12),
        make_coef(-1052755, 14)
    };

    // upper range padded with zero leading terms
    localparam logic signed [63:0] HI_COEF [NCOEF] = '{
        make_coef(-1318058, 4), make_coef(4830222, 5), make_coef(-1646031, 6),
        make_coef(5464731, 8), make_coef(-9650715, 10), make_coef(8802193, 12),
        make_coef(-3110810, 14), 64'sd0, 64'sd0, 64'sd0
    };

endpackage

/* src/tcat_div.sv */
// ----------------------------------------------------------------------------
// tcat_div
// Pipelined restoring divider: one quotient bit per stage, code << FRAC / gain.
// ----------------------------------------------------------------------------
module tcat_div
    import tcat_pkg::*;
#(
    parameter int FRAC_BITS = 20
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [ADC_W-1:0]            i_tc,
    input  logic [9:0]                  i_gain,
    input  t_side                       i_side,
    output logic                        o_valid,
    output logic [ADC_W+FRAC_BITS-1:0]  o_quo,
    output t_side                       o_side
);

    localparam int DW = ADC_W + FRAC_BITS;

    logic          r_v    [DW];
    logic [9:0]    r_rem  [DW];
    logic [DW-1:0] r_num  [DW];
    logic [DW-1:0] r_quo  [DW];
    t_side         r_side [DW];

    for (genvar k = 0; k < DW; k++) begin : g_st
        logic          w_v;
        logic [9:0]    w_rem;
        logic [DW-1:0] w_num;
        logic [DW-1:0] w_quo;
        t_side         w_side;
        logic [10:0]   w_try;
        logic          w_ge;

        if (k == 0) begin : g_first
            assign w_v    = i_valid;
            assign w_rem  = '0;
            assign w_num  = {i_tc, {FRAC_BITS{1'b0}}};
            assign w_quo  = '0;
            assign w_side = i_side;
        end else begin : g_next
            assign w_v    = r_v[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_num  = r_num[k-1];
            assign w_quo  = r_quo[k-1];
            assign w_side = r_side[k-1];
        end

        assign w_try = {w_rem, w_num[DW-1]};
        assign w_ge  = (w_try >= {1'b0, i_gain});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? 10'(w_try - {1'b0, i_gain}) : w_try[9:0];
                r_num[k]  <= w_num << 1;
                r_quo[k]  <= {w_quo[DW-2:0], w_ge};
                r_side[k] <= w_side;
            end
        end
    end

    assign o_valid = r_v[DW-1];
    assign o_quo   = r_quo[DW-1];
    assign o_side  = r_side[DW-1];

endmodule

/* src/tcat_horner.sv */
// ----------------------------------------------------------------------------
// tcat_horner
// Polynomial evaluation, three register stages per Horner step.
// ----------------------------------------------------------------------------
module tcat_horner
    import tcat_pkg::*;
#(
    parameter int FRAC_BITS = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [FRAC_BITS+5:0]  i_e,
    input  logic                  i_hi,
    input  t_side                 i_side,
    output logic                  o_valid,
    output logic signed [63:0]    o_acc,
    output t_side                 o_side
);

    localparam int EW = FRAC_BITS + 6;
    localparam int PW = 63 + EW;
    localparam int RW = PW - FRAC_BITS;

    // stage A: sign and magnitude
    logic          r_av    [NSTEP];
    logic          r_aneg  [NSTEP];
    logic [62:0]   r_amag  [NSTEP];
    logic [EW-1:0] r_ae    [NSTEP];
    logic          r_ahi   [NSTEP];
    t_side         r_aside [NSTEP];
    // stage B: partial products
    logic             r_bv    [NSTEP];
    logic             r_bneg  [NSTEP];
    logic [32+EW-1:0] r_bpl   [NSTEP];
    logic [31+EW-1:0] r_bph   [NSTEP];
    logic [EW-1:0]    r_be    [NSTEP];
    logic             r_bhi   [NSTEP];
    t_side            r_bside [NSTEP];
    // stage C: shift, add coefficient, saturate
    logic               r_cv    [NSTEP];
    logic signed [63:0] r_cacc  [NSTEP];
    logic [EW-1:0]      r_ce    [NSTEP];
    logic               r_chi   [NSTEP];
    t_side              r_cside [NSTEP];

    for (genvar j = 0; j < NSTEP; j++) begin : g_step
        localparam int CI = NCOEF - 2 - j;
        logic               w_v;
        logic signed [63:0] w_acc;
        logic [EW-1:0]      w_e;
        logic               w_hi;
        t_side              w_side;
        logic signed [63:0] w_sum;

        if (j == 0) begin : g_first
            assign w_v    = i_valid;
            assign w_acc  = i_hi ? HI_COEF[NCOEF-1] : LO_COEF[NCOEF-1];
            assign w_e    = i_e;
            assign w_hi   = i_hi;
            assign w_side = i_side;
        end else begin : g_next
            assign w_v    = r_cv[j-1];
            assign w_acc  = r_cacc[j-1];
            assign w_e    = r_ce[j-1];
            assign w_hi   = r_chi[j-1];
            assign w_side = r_cside[j-1];
        end

        always_comb begin
            logic [PW-1:0]      full;
            logic [RW-1:0]      res;
            logic [62:0]        mag;
            logic signed [64:0] sp;
            logic signed [64:0] sum;
            full = {r_bph[j], 32'd0} + PW'(r_bpl[j]);
            res  = RW'(full >> FRAC_BITS);
            mag  = (res > RW'(ACC_LIM)) ? 63'(ACC_LIM) : res[62:0];
            sp   = r_bneg[j] ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
            sum  = sp + 65'(r_bhi[j] ? HI_COEF[CI] : LO_COEF[CI]);
            if (sum > 65'(ACC_LIM)) begin
                w_sum = ACC_LIM;
            end else if (sum < -65'(ACC_LIM)) begin
                w_sum = -ACC_LIM;
            end else begin
                w_sum = sum[63:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_av[j] <= 1'b0;
                r_bv[j] <= 1'b0;
                r_cv[j] <= 1'b0;
            end else if (i_en) begin
                r_av[j] <= w_v;
                r_bv[j] <= r_av[j];
                r_cv[j] <= r_bv[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_aneg[j]  <= w_acc[63];
                r_amag[j]  <= w_acc[63] ? 63'(-w_acc) : w_acc[62:0];
                r_ae[j]    <= w_e;
                r_ahi[j]   <= w_hi;
                r_aside[j] <= w_side;

                r_bneg[j]  <= r_aneg[j];
                r_bpl[j]   <= r_amag[j][31:0] * r_ae[j];
                r_bph[j]   <= r_amag[j][62:32] * r_ae[j];
                r_be[j]    <= r_ae[j];
                r_bhi[j]   <= r_ahi[j];
                r_bside[j] <= r_aside[j];

                r_cacc[j]  <= w_sum;
                r_ce[j]    <= r_be[j];
                r_chi[j]   <= r_bhi[j];
                r_cside[j] <= r_bside[j];
            end
        end
    end

    assign o_valid = r_cv[NSTEP-1];
    assign o_acc   = r_cacc[NSTEP-1];
    assign o_side  = r_cside[NSTEP-1];

endmodule

/* src/thermocouple_adc_to_temperature.sv */
// ----------------------------------------------------------------------------
// thermocouple_adc_to_temperature
// Type K thermocouple code to degrees Celsius with cold-junction subtraction.
//
//   channel | dir | words
//   s       | in  | tdata: tc_adc[11:0], ambient_adc[23:12]
//   m       | out | tdata: temperature[15:0]; tuser: status[1:0], link_event[3:2]
//   apb     | in  | open_threshold 0x0, range_limit 0x4, amp_gain 0x8, error_value 0xC
//
// One word per cycle while the sink does not stall; the depth is set by
// the bit-per-stage divider and three stages per Horner step over nine steps.
// Reset clears all valid bits and loads the register defaults.
// A stall holds the whole pipe; a skid word lets one more word drain into it.
// ----------------------------------------------------------------------------
module thermocouple_adc_to_temperature
    import tcat_pkg::*;
#(
    parameter int FRAC_BITS = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // tc_adc[11:0], ambient_adc[23:12]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // temperature[15:0]
    output logic [3:0]  o_m_tuser,   // status[1:0], link_event[3:2]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int EW = FRAC_BITS + 6;
    localparam int DW = ADC_W + FRAC_BITS;
    localparam logic [EW+9:0] BR_LIM = (EW + 10)'(20645) << FRAC_BITS;

    logic [11:0] r_open;
    logic [11:0] r_range;
    logic [9:0]  r_gain;
    logic [15:0] r_err;

    logic en;
    logic r_skid_v;

    // ---- configuration
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open  <= 12'd4000;
            r_range <= 12'd3900;
            r_gain  <= 10'd100;
            r_err   <= 16'hFFFF;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_OPEN:  r_open  <= pwdata[11:0];
                REG_RANGE: r_range <= pwdata[11:0];
                REG_GAIN:  r_gain  <= pwdata[9:0];
                REG_ERR:   r_err   <= pwdata[15:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_OPEN:  prdata = 32'(r_open);
            REG_RANGE: prdata = 32'(r_range);
            REG_GAIN:  prdata = 32'(r_gain);
            REG_ERR:   prdata = 32'(r_err);
            default:   prdata = '0;
        endcase
    end

    // ---- entry stage: classify, ambient degrees
    logic              r_s0_v;
    logic [ADC_W-1:0]  r_s0_tc;
    t_side             r_s0_side;
    t_side             n_s0_side;
    logic [ADC_W-1:0]  w_tc;
    logic [ADC_W-1:0]  w_amb_adc;
    logic [27:0]       w_amb_prod;

    assign en         = !r_skid_v;
    assign o_s_tready = en;
    assign w_tc       = i_s_tdata[11:0];
    assign w_amb_adc  = i_s_tdata[23:12];
    // divide by ten: times 52429, drop 19 bits
    assign w_amb_prod = w_amb_adc * 16'd52429;

    always_comb begin
        n_s0_side.amb = AMB_W'(w_amb_prod >> 19);
        if (w_tc > r_open) begin
            n_s0_side.status = ST_OPEN;
            n_s0_side.link   = LNK_FAIL;
        end else if (w_tc > r_range || r_gain == '0) begin
            n_s0_side.status = ST_RANGE;
            n_s0_side.link   = LNK_NONE;
        end else begin
            n_s0_side.status = ST_OK;
            n_s0_side.link   = LNK_PASS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (en) begin
            r_s0_v <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_tc   <= w_tc;
            r_s0_side <= n_s0_side;
        end
    end

    // ---- EMF division
    logic          d_v;
    logic [DW-1:0] d_quo;
    t_side         d_side;

    tcat_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s0_v),
        .i_tc    (r_s0_tc),
        .i_gain  (r_gain),
        .i_side  (r_s0_side),
        .o_valid (d_v),
        .o_quo   (d_quo),
        .o_side  (d_side)
    );

    // ---- clamp below 64 mV and pick the range
    logic          r_e_v;
    logic [EW-1:0] r_e;
    logic          r_e_hi;
    t_side         r_e_side;
    logic [EW-1:0] w_e;

    assign w_e = (|d_quo[DW-1:EW]) ? {EW{1'b1}} : d_quo[EW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else if (en) begin
            r_e_v <= d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e      <= w_e;
            r_e_hi   <= !((w_e * (EW + 10)'(1000)) < BR_LIM);
            r_e_side <= d_side;
        end
    end

    // ---- polynomial
    logic               h_v;
    logic signed [63:0] h_acc;
    t_side              h_side;

    tcat_horner #(.FRAC_BITS(FRAC_BITS)) u_horner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_e_v),
        .i_e     (r_e),
        .i_hi    (r_e_hi),
        .i_side  (r_e_side),
        .o_valid (h_v),
        .o_acc   (h_acc),
        .o_side  (h_side)
    );

    // ---- whole degrees, ambient subtraction, error selection
    logic              r_out_v;
    logic [15:0]       r_out_temp;
    logic [3:0]        r_out_user;
    logic [15:0]       n_out_temp;
    logic [3:0]        n_out_user;
    logic [MEAS_W-1:0] w_meas;

    assign w_meas = h_acc[63] ? '0 : h_acc[COEF_FR+MEAS_W-1:COEF_FR];

    always_comb begin
        if (h_side.status != ST_OK) begin
            n_out_temp = r_err;
            n_out_user = {h_side.link, h_side.status};
        end else if (w_meas < MEAS_W'(h_side.amb)) begin
            n_out_temp = r_err;
            n_out_user = {LNK_PASS, ST_BELOW};
        end else begin
            n_out_temp = 16'(w_meas - MEAS_W'(h_side.amb));
            n_out_user = {LNK_PASS, ST_OK};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= h_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_temp <= n_out_temp;
            r_out_user <= n_out_user;
        end
    end

    // ---- skid word: catch the last stage when the sink stalls
    logic [15:0] r_skid_temp;
    logic [3:0]  r_skid_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            r_skid_v <= !i_m_tready;
        end else begin
            r_skid_v <= r_out_v && !i_m_tready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_v) begin
            r_skid_temp <= r_out_temp;
            r_skid_user <= r_out_user;
        end
    end

    assign o_m_tvalid = r_skid_v || r_out_v;
    assign o_m_tdata  = r_skid_v ? r_skid_temp : r_out_temp;
    assign o_m_tuser  = r_skid_v ? r_skid_user : r_out_user;

endmodule

/* src/tcat_chk.sv */
// ----------------------------------------------------------------------------
// tcat_chk
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
module tcat_chk
    import tcat_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic [3:0]  o_m_tuser
);

    // hold a stalled word
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser))
        else $error("stalled word changed");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("word after reset");

    a_ok_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser[1:0] == ST_OK || o_m_tuser[1:0] == ST_BELOW)
            |-> o_m_tuser[3:2] == LNK_PASS)
        else $error("measured word without link pass");

    a_open_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1:0] == ST_OPEN |-> o_m_tuser[3:2] == LNK_FAIL)
        else $error("open circuit without link fail");

    a_range_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1:0] == ST_RANGE |-> o_m_tuser[3:2] == LNK_NONE)
        else $error("out of range with link report");

endmodule

bind thermocouple_adc_to_temperature tcat_chk u_tcat_chk (.*);

/* dv/thermocouple_adc_to_temperature_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermocouple_adc_to_temperature_tb
// Drives code pairs through the converter under several register settings,
// with bursty input and a stalling output, and checks every word against a
// typed expectation or a bit-exact predictor of the type K inverse polynomial.
// ----------------------------------------------------------------------------
module thermocouple_adc_to_temperature_tb
    import tcat_pkg::*;
();

    localparam int  FRAC       = 20;
    localparam int  CFRAC      = 48;
    localparam int  WATCH_LIM  = 5000;
    localparam int  DRAIN_WAIT = 80;
    localparam longint SAT     = 64'sd1 <<< 62;

    typedef struct packed {
        logic [15:0] temp;
        logic [1:0]  st;
        logic [1:0]  lnk;
    } t_reading;

    typedef struct {
        logic [11:0] tc;
        logic [11:0] amb;
        bit          typed;
        t_reading    want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata = '0;   // tc_adc[11:0], ambient_adc[23:12]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;        // temperature[15:0]
    logic [3:0]  o_m_tuser;        // status[1:0], link_event[3:2]
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    thermocouple_adc_to_temperature #(.FRAC_BITS(FRAC)) dut (.*);

    always #2 i_clk = ~i_clk;

    logic [11:0] cfg_open = 12'd4000;
    logic [11:0] cfg_range = 12'd3900;
    logic [9:0]  cfg_gain = 10'd100;
    logic [15:0] cfg_err = 16'hFFFF;

    longint   lo_c [10];
    longint   hi_c [7];
    t_reading pending_readings [$];
    int       errors = 0;
    int       quiet = 0;
    bit       cur_typed = 1'b0;
    t_reading cur_want = '0;
    int       rx_cycle = 0;
    int       sent = 0;

    // mant / 10^exp scaled by 2^48, truncated toward zero
    function automatic longint coef(input int mant, input int exp10);
        logic [63:0] mag, den, q, r, fr;
        int i;
        mag = (mant < 0) ? 64'(-mant) : 64'(mant);
        den = 64'd1;
        for (i = 0; i < exp10; i++) den = den * 64'd10;
        q = mag / den;
        r = mag % den;
        fr = '0;
        for (i = 0; i < CFRAC; i++) begin
            r = r << 1;
            fr = fr << 1;
            if (r >= den) begin
                r = r - den;
                fr[0] = 1'b1;
            end
        end
        mag = (q << CFRAC) | fr;
        return (mant < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint eval_poly(input bit upper, input logic [63:0] e);
        longint acc, p, c;
        logic [63:0]  mag;
        logic [127:0] prod;
        int n, i;
        n = upper ? 7 : 10;
        acc = upper ? hi_c[6] : lo_c[9];
        for (i = n - 2; i >= 0; i--) begin
            mag = (acc < 0) ? 64'(-acc) : 64'(acc);
            prod = ({64'b0, mag} * {64'b0, e}) >> FRAC;
            p = (prod > 128'(SAT)) ? SAT : longint'(prod[63:0]);
            c = upper ? hi_c[i] : lo_c[i];
            acc = ((acc < 0) ? -p : p) + c;
            if (acc > SAT) acc = SAT;
            if (acc < -SAT) acc = -SAT;
        end
        return acc;
    endfunction

    function automatic t_reading convert(input logic [11:0] tc, input logic [11:0] amb_code);
        t_reading    r;
        logic [63:0] e, amb, meas;
        longint      acc;
        amb = 64'(amb_code) / 10;
        if (tc > cfg_open) return '{cfg_err, ST_OPEN, LNK_FAIL};
        if (tc > cfg_range || cfg_gain == 0) return '{cfg_err, ST_RANGE, LNK_NONE};
        e = (64'(tc) << FRAC) / 64'(cfg_gain);
        if (e > (64'd64 << FRAC) - 1) e = (64'd64 << FRAC) - 1;
        acc = eval_poly(e * 1000 >= (64'd20645 << FRAC), e);
        if (acc < 0) meas = 0;
        else begin
            meas = 64'(acc) >> CFRAC;
            if (meas > 65535) meas = 65535;
        end
        if (meas < amb) return '{cfg_err, ST_BELOW, LNK_PASS};
        r.temp = 16'(meas - amb);
        r.st = ST_OK;
        r.lnk = LNK_PASS;
        return r;
    endfunction

    task automatic report(input string what, input t_reading got, input t_reading want);
        $display("mismatch %s: got t=%0d st=%0d lnk=%0d, want t=%0d st=%0d lnk=%0d",
                 what, got.temp, got.st, got.lnk, want.temp, want.st, want.lnk);
        errors++;
    endtask

    // record accepted words and check results on the same edge
    always @(posedge i_clk) begin
        t_reading got, want;
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) quiet <= 0;
            else quiet <= quiet + 1;
            if (i_s_tvalid && o_s_tready)
                pending_readings.push_back(cur_typed ? cur_want
                    : convert(i_s_tdata[11:0], i_s_tdata[23:12]));
            if (o_m_tvalid && i_m_tready) begin
                got = '{o_m_tdata, o_m_tuser[1:0], o_m_tuser[3:2]};
                if (pending_readings.size() == 0) report("unexpected word", got, got);
                else begin
                    want = pending_readings.pop_front();
                    if (got.temp !== want.temp) report("temperature", got, want);
                    else if (got.st !== want.st) report("status", got, want);
                    else if (got.lnk !== want.lnk) report("link_event", got, want);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (quiet >= WATCH_LIM) begin
            $display("FAIL thermocouple_adc_to_temperature");
            $finish;
        end
    end

    // receiver: stall pattern drawn at random among four modes, two long hold-offs
    // placed well inside random phases so the sender keeps offering
    always @(posedge i_clk) begin
        int hold, mode, holds_done;
        if (rx_cycle % 150 == 0) mode = $urandom_range(0, 3);
        if ((holds_done == 0 && sent >= 330) || (holds_done == 1 && sent >= 1300)) begin
            hold = 400;
            holds_done++;
        end
        rx_cycle <= rx_cycle + 1;
        if (hold > 0) begin
            hold--;
            i_m_tready <= 1'b0;
        end else begin
            case (mode)
                0: i_m_tready <= 1'b1;
                1: i_m_tready <= ($urandom_range(0, 3) != 0);
                2: i_m_tready <= ($urandom_range(0, 1) != 0);
                default: i_m_tready <= ((rx_cycle % 7) < 2);
            endcase
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_OPEN:  cfg_open = val[11:0];
            REG_RANGE: cfg_range = val[11:0];
            REG_GAIN:  cfg_gain = val[9:0];
            default:   cfg_err = val[15:0];
        endcase
    endtask

    task automatic settle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    int burst = 0;

    // hold the word until taken, then maybe insert a gap
    task automatic send(input logic [11:0] tc, input logic [11:0] amb,
                        input bit typed, input t_reading want);
        int gap;
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {amb, tc};
        cur_typed <= typed;
        cur_want <= want;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sent++;
        if (burst == 0) begin
            burst = $urandom_range(1, 30);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else burst--;
    endtask

    task automatic random_phase(input int n);
        logic [11:0] tc, amb;
        int k;
        for (k = 0; k < n; k++) begin
            case ($urandom_range(0, 9))
                0: tc = 12'($urandom_range(0, 4095));
                1: tc = 12'($urandom_range(cfg_range, 4095));
                default: tc = 12'($urandom_range(0, cfg_range));
            endcase
            amb = ($urandom_range(0, 4) == 0) ? 12'($urandom_range(0, 4095))
                                              : 12'($urandom_range(0, 400));
            send(tc, amb, 1'b0, '0);
        end
    endtask

    t_row dir_rows [$];

    initial begin
        int i;
        t_row r;
        lo_c = '{coef(0, 0), coef(2508355, 5), coef(7860106, 8), coef(-2503131, 7),
                 coef(8315270, 8), coef(-1228034, 8), coef(9804036, 10),
                 coef(-4413030, 11), coef(1057734, 12), coef(-1052755, 14)};
        hi_c = '{coef(-1318058, 4), coef(4830222, 5), coef(-1646031, 6),
                 coef(5464731, 8), coef(-9650715, 10), coef(8802193, 12),
                 coef(-3110810, 14)};
        // typed rows: open, out of range, zero input, below ambient
        dir_rows.push_back('{12'd4095, 12'd0,    1, '{16'hFFFF, ST_OPEN,  LNK_FAIL}});
        dir_rows.push_back('{12'd4001, 12'd4095, 1, '{16'hFFFF, ST_OPEN,  LNK_FAIL}});
        dir_rows.push_back('{12'd3950, 12'd0,    1, '{16'hFFFF, ST_RANGE, LNK_NONE}});
        dir_rows.push_back('{12'd4000, 12'd0,    1, '{16'hFFFF, ST_RANGE, LNK_NONE}});
        dir_rows.push_back('{12'd0,    12'd0,    1, '{16'd0,    ST_OK,    LNK_PASS}});
        dir_rows.push_back('{12'd0,    12'd10,   1, '{16'hFFFF, ST_BELOW, LNK_PASS}});
        dir_rows.push_back('{12'd0,    12'd9,    1, '{16'd0,    ST_OK,    LNK_PASS}});
        // predicted rows: branch edge, range edge, full ambient
        dir_rows.push_back('{12'd2064, 12'd0,    0, '0});
        dir_rows.push_back('{12'd2065, 12'd0,    0, '0});
        dir_rows.push_back('{12'd3900, 12'd0,    0, '0});
        dir_rows.push_back('{12'd3900, 12'd4095, 0, '0});
        dir_rows.push_back('{12'd500,  12'd4095, 0, '0});
        dir_rows.push_back('{12'd1,    12'd0,    0, '0});
        dir_rows.push_back('{12'd2555, 12'd2730, 0, '0});
        dir_rows.push_back('{12'd1000, 12'd250,  0, '0});
        dir_rows.push_back('{12'd3000, 12'd1,    0, '0});

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        foreach (dir_rows[i]) begin
            r = dir_rows[i];
            send(r.tc, r.amb, r.typed, r.want);
        end
        random_phase(200);
        settle();

        // extremes: every nonzero code open, gain one saturates the EMF, error value zero
        write_reg(REG_OPEN, 32'd0);
        write_reg(REG_ERR, 32'd0);
        random_phase(60);
        settle();
        write_reg(REG_OPEN, 32'd4095);
        write_reg(REG_RANGE, 32'd4095);
        write_reg(REG_GAIN, 32'd1);
        random_phase(250);
        settle();
        write_reg(REG_GAIN, 32'd1023);
        write_reg(REG_RANGE, 32'd0);
        write_reg(REG_ERR, 32'hA5A5);
        random_phase(200);
        settle();
        // zero gain counts as out of range
        write_reg(REG_RANGE, 32'd4095);
        write_reg(REG_GAIN, 32'd0);
        random_phase(60);
        settle();
        for (i = 0; i < 4; i++) begin
            write_reg(REG_OPEN, 32'($urandom_range(2000, 4095)));
            write_reg(REG_RANGE, 32'($urandom_range(1000, 4095)));
            write_reg(REG_GAIN, 32'($urandom_range(20, 300)));
            write_reg(REG_ERR, 32'($urandom_range(0, 65535)));
            random_phase(250);
            settle();
        end

        if (errors == 0) begin
            $display("PASS thermocouple_adc_to_temperature");
        end else begin
            $display("FAIL thermocouple_adc_to_temperature");
        end
        $finish;
    end

endmodule
